// ===== src/rsk_pkg.sv =====
// rsk_pkg: types, register map and channel arithmetic of the cross-kernel sharpening filter
// shared by rsk_sharpen_unit and rgb_sharpen_cross_kernel; no dependencies

package rsk_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic kernel_en;
      logic wrap;
   } sharpen_ctl_type;

   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_WRAP_MODE    = 2'd2;

   localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic        WRAP_MODE_RESET    = 1'b0;

   // 5*c - u - d - l - r, clamped to 0..255 or wrapped to 8 bits
   function automatic logic [7:0] sharpen_chan(input logic [7:0] c, input logic [7:0] u,
                                                input logic [7:0] d, input logic [7:0] l,
                                                input logic [7:0] r, input logic wrap);
      logic [10:0] five_c;
      logic [9:0]  nsum;
      logic [11:0] s;
      logic [7:0]  res;
      five_c = {1'b0, c, 2'b00} + {3'b000, c};
      nsum   = {2'b00, u} + {2'b00, d} + {2'b00, l} + {2'b00, r};
      s      = {1'b0, five_c} - {2'b00, nsum};
      if (wrap) begin
         res = s[7:0];
      end else if (s[11]) begin
         res = 8'd0;
      end else if (s[10:8] != 3'd0) begin
         res = 8'd255;
      end else begin
         res = s[7:0];
      end
      return res;
   endfunction

endpackage

// ===== src/rgb_sharpen_cross_kernel.sv =====
// rgb_sharpen_cross_kernel: 3x3 cross-kernel sharpening of an rgb raster stream
// depends on rsk_pkg and rsk_sharpen_unit
//
// req_ channel takes pixels in raster order (tuser 0) and, after the last row,
// flush items (tuser 1) that drain the last row. rsp_ channel returns each pixel one
// row behind its input: interior pixels get 5*centre minus the four cross neighbours,
// border pixels pass unchanged. tlast marks the last pixel of an output row, tuser
// the last output pixel of the frame. pixels of the first row give no item; pixels
// while draining and flush items while taking pixels are dropped.
// one item per cycle sustained while rsp_tready is high; the line stores are read
// at the accepting edge into the read stage, then kernel into the output register.
// the csr_ apb port holds frame_width (0x0), frame_height (0x4) and wrap_mode (0x8).
// reset clears the counters, csr registers and valid flags; the line stores are
// not cleared and hold nothing usable until a row has been written.
// while rsp_tready is low the output register and the read stage hold; req_tready
// drops once both are full.

module rgb_sharpen_cross_kernel import rsk_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // in_red, in_green, in_blue
   input  logic [0:0]  req_tuser,    // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // out_red, out_green, out_blue
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,    // frame_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int CW = (XW + 1 > 12) ? XW + 1 : 12;
   localparam int HW = (YW + 1 > 13) ? YW + 1 : 13;

   typedef struct packed {
      logic [XW-1:0] addr;
      pixel_type     down;
      logic          produce;
      logic          pixel;
      logic          kernel_en;
      logic          row_end;
      logic          frame_end;
   } stage_type;

   logic [11:0] fw_ff;
   logic [12:0] fh_ff;
   logic        wrap_ff;
   logic [1:0]  csr_idx;
   logic        csr_we;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= FRAME_WIDTH_RESET;
         fh_ff   <= FRAME_HEIGHT_RESET;
         wrap_ff <= WRAP_MODE_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            REG_FRAME_WIDTH:  fw_ff   <= csr_pwdata[11:0];
            REG_FRAME_HEIGHT: fh_ff   <= csr_pwdata[12:0];
            REG_WRAP_MODE:    wrap_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FRAME_WIDTH:  csr_prdata = {20'd0, fw_ff};
         REG_FRAME_HEIGHT: csr_prdata = {19'd0, fh_ff};
         REG_WRAP_MODE:    csr_prdata = {31'd0, wrap_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // effective size minus one
   logic [CW-1:0] fw_x;
   logic [HW-1:0] fh_x;
   logic [XW-1:0] wm1;
   logic [YW-1:0] hm1;

   assign fw_x = CW'(fw_ff);
   assign fh_x = HW'(fh_ff);

   always_comb begin
      if (fw_x == '0) begin
         wm1 = '0;
      end else if (fw_x > CW'(MAX_WIDTH)) begin
         wm1 = XW'(MAX_WIDTH - 1);
      end else begin
         wm1 = XW'(fw_x - CW'(1));
      end
      if (fh_x == '0) begin
         hm1 = '0;
      end else if (fh_x > HW'(MAX_HEIGHT)) begin
         hm1 = YW'(MAX_HEIGHT - 1);
      end else begin
         hm1 = YW'(fh_x - HW'(1));
      end
   end

   // position and drain state
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic          drain_ff, drain_in;
   logic          accept, take, in_pixel, last_col;
   logic [XW-1:0] right_addr;
   pixel_type     in_px;

   assign accept     = req_tvalid && req_tready;
   assign in_pixel   = !req_tuser[0];
   assign take       = accept && (drain_ff ? !in_pixel : in_pixel);
   assign last_col   = col_ff >= wm1;
   assign in_px      = '{red: req_tdata[7:0], green: req_tdata[15:8], blue: req_tdata[23:16]};
   assign right_addr = (col_ff == XW'(MAX_WIDTH - 1)) ? '0 : col_ff + XW'(1);

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      if (take) begin
         if (last_col) begin
            col_in = '0;
            if (drain_ff) begin
               row_in   = '0;
               drain_in = 1'b0;
            end else if (row_ff >= hm1) begin
               drain_in = 1'b1;
            end else begin
               row_in = row_ff + YW'(1);
            end
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
      end
   end

   // read stage
   logic      s1_valid_ff;
   stage_type s1_ff, s1_in;
   logic      s1_fire;
   logic      out_valid_ff;
   pixel_type out_px_ff;
   logic      out_row_end_ff, out_frame_end_ff;

   assign s1_fire    = s1_valid_ff && (!s1_ff.produce || !out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_in.addr      = col_ff;
      s1_in.down      = in_px;
      s1_in.produce   = drain_ff || (row_ff != '0);
      s1_in.pixel     = !drain_ff;
      s1_in.kernel_en = !drain_ff && (row_ff >= YW'(2)) && (row_ff <= hm1) &&
                        (col_ff != '0) && (col_ff < wm1);
      s1_in.row_end   = last_col;
      s1_in.frame_end = drain_ff && last_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_ff <= s1_in;
      end
   end

   // line stores
   pixel_type mid_mem [MAX_WIDTH];
   pixel_type up_mem  [MAX_WIDTH];
   pixel_type mid_c_rd_ff, mid_r_rd_ff, up_rd_ff;
   logic      up_we;

   assign up_we = s1_fire && s1_ff.pixel;

   always_ff @(posedge clock) begin
      if (take) begin
         mid_c_rd_ff <= mid_mem[col_ff];
         mid_r_rd_ff <= mid_mem[right_addr];
      end
      if (take && in_pixel) begin
         mid_mem[col_ff] <= in_px;
      end
   end

   always_ff @(posedge clock) begin
      if (up_we) begin
         up_mem[s1_ff.addr] <= mid_c_rd_ff;
      end
      if (take) begin
         if (up_we && (s1_ff.addr == col_ff)) begin
            up_rd_ff <= mid_c_rd_ff;
         end else begin
            up_rd_ff <= up_mem[col_ff];
         end
      end
   end

   pixel_type left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (up_we) begin
         left_ff <= mid_c_rd_ff;
      end
   end

   // kernel and output register
   sharpen_ctl_type ctl;
   pixel_type       result;

   assign ctl = '{kernel_en: s1_ff.kernel_en, wrap: wrap_ff};

   rsk_sharpen_unit u_sharpen (
      .centre (mid_c_rd_ff),
      .up     (up_rd_ff),
      .down   (s1_ff.down),
      .left   (left_ff),
      .right  (mid_r_rd_ff),
      .ctl    (ctl),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire && s1_ff.produce) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_ff.produce) begin
         out_px_ff        <= result;
         out_row_end_ff   <= s1_ff.row_end;
         out_frame_end_ff <= s1_ff.frame_end;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_px_ff.blue, out_px_ff.green, out_px_ff.red};
   assign rsp_tlast    = out_row_end_ff;
   assign rsp_tuser[0] = out_frame_end_ff;

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end without row end");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_ff.addr))
      else $error("read stage lost its item while stalled");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= XW'(MAX_WIDTH - 1))
      else $error("column counter beyond line store");

   a_no_take_when_blocked: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.produce && out_valid_ff && !rsp_tready |-> !take)
      else $error("item taken while read stage blocked");

endmodule

// ===== src/rsk_sharpen_unit.sv =====
// rsk_sharpen_unit: applies the cross kernel to all three channels of one pixel
// or passes the centre through at the border; depends on rsk_pkg

module rsk_sharpen_unit import rsk_pkg::*; (
   input  pixel_type       centre,
   input  pixel_type       up,
   input  pixel_type       down,
   input  pixel_type       left,
   input  pixel_type       right,
   input  sharpen_ctl_type ctl,
   output pixel_type       result
);

   always_comb begin
      if (ctl.kernel_en) begin
         result.red   = sharpen_chan(centre.red, up.red, down.red, left.red, right.red,
                                     ctl.wrap);
         result.green = sharpen_chan(centre.green, up.green, down.green, left.green,
                                     right.green, ctl.wrap);
         result.blue  = sharpen_chan(centre.blue, up.blue, down.blue, left.blue,
                                     right.blue, ctl.wrap);
      end else begin
         result = centre;
      end
   end

endmodule
